[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers included by the compressor top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[sv/dcmp_pkg.sv]
// ----------------------------------------------------------------------------
// dcmp_pkg
// Types, sizes and the hash function of the phrase dictionary compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmp_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int IDX_W        = $clog2(DICT_ENTRIES);
    localparam int FREE_W       = IDX_W + 1;
    localparam int SYM_W        = 8;
    localparam int KEY_W        = IDX_W + SYM_W;
    // The hash table has twice as many slots as the dictionary has entries.
    localparam int SLOT_W       = IDX_W + 1;

    typedef struct packed {
        logic [SYM_W-1:0] data_byte;
        logic             end_marker;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] prefix_index;
        logic [SYM_W-1:0] out_symbol;
        logic             last_tuple;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic      load;
        out_item_t item;
    } emit_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } ctrl_status_t;

    // Fold a (prefix, symbol) key into a slot address.
    function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
        logic [SLOT_W-1:0] low_part;
        logic [SLOT_W-1:0] high_part;
        low_part  = key[SLOT_W-1:0];
        high_part = SLOT_W'(key[KEY_W-1:SLOT_W]) << 3;
        return low_part ^ high_part;
    endfunction

endpackage

`default_nettype wire

[sv/dcmp_table.sv]
// ----------------------------------------------------------------------------
// dcmp_table
// Hash table memory with separate write and read ports and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmp_table
    import dcmp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire slot_t             wr_data,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output slot_t                  rd_data
);

    slot_t mem [2**SLOT_W];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[sv/dcmp_ctrl.sv]
// ----------------------------------------------------------------------------
// dcmp_ctrl
// Sequencer that probes the hash table, inserts phrases and clears it.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmp_ctrl
    import dcmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_take,
    input  wire in_item_t in_item,
    input  wire logic     out_busy,
    output emit_t         emit,
    output ctrl_status_t  status
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  match_reg, match_next;
    logic [FREE_W-1:0] free_reg, free_next;
    logic [SLOT_W-1:0] addr_reg, addr_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              end_reg, end_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
    slot_t             rd_data;

    dcmp_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Next-state logic: one probe compare per table read.
    always_comb
    begin
        state_next   = state_reg;
        match_next   = match_reg;
        free_next    = free_reg;
        addr_next    = addr_reg;
        key_next     = key_reg;
        end_next     = end_reg;
        res_idx_next = res_idx_reg;
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = '0;
        emit         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (&addr_reg)
                begin
                    match_next = '0;
                    free_next  = FREE_W'(1);
                    end_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_item.end_marker)
                    begin
                        key_next     = {match_reg, {SYM_W{1'b0}}};
                        res_idx_next = match_reg;
                        end_next     = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        key_next   = {match_reg, in_item.data_byte};
                        addr_next  = slot_hash({match_reg, in_item.data_byte});
                        end_next   = 1'b0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_data.valid && (rd_data.key == key_reg))
                begin
                    match_next = rd_data.idx;
                    state_next = S_IDLE;
                end
                else if (!rd_data.valid)
                begin
                    res_idx_next = match_reg;
                    if (free_reg < FREE_W'(DICT_ENTRIES))
                    begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.key   = key_reg;
                        wr_data.idx   = free_reg[IDX_W-1:0];
                        free_next     = free_reg + 1'b1;
                    end
                    match_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    emit.load              = 1'b1;
                    emit.item.prefix_index = res_idx_reg;
                    emit.item.out_symbol   = key_reg[SYM_W-1:0];
                    emit.item.last_tuple   = end_reg;
                    if (end_reg)
                    begin
                        addr_next  = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign status.clearing = (state_reg == S_CLEAR);
    assign status.busy     = (state_reg != S_IDLE);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            match_reg <= '0;
            free_reg  <= FREE_W'(1);
            addr_reg  <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            match_reg <= match_next;
            free_reg  <= free_next;
            addr_reg  <= addr_next;
            end_reg   <= end_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        res_idx_reg <= res_idx_next;
    end

endmodule

`default_nettype wire

[sv/lz78_dictionary_compressor.sv]
// ----------------------------------------------------------------------------
// lz78_dictionary_compressor
// Phrase dictionary compressor: one byte in, zero or one tuple out.
// ----------------------------------------------------------------------------
// The dictionary lives in an 8192-slot hash table with linear probing in a
// memory with separate write and read ports. Each byte is taken in, then
// probed, each probe setting the address and then doing the registered read
// and compare; at most half the slots are ever filled. A result is loaded
// into the output register once that register is free. After reset and
// after every end item the table is swept clean, one slot a cycle, during
// which no input is taken.
`default_nettype none

`include "assert_macros.svh"

module lz78_dictionary_compressor
    import dcmp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    emit_t        emit;
    ctrl_status_t status;
    logic         out_valid_reg;
    out_item_t    out_data_reg;
    logic         out_busy;
    logic         in_take;

    assign in_stall = status.busy;
    assign in_take  = in_valid && !status.busy;
    assign out_busy = out_valid_reg && out_stall;

    dcmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .in_item  (in_data),
        .out_busy (out_busy),
        .emit     (emit),
        .status   (status)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_data_reg <= emit.item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A result is only loaded when the output register is free.
    `ASSERT_IMPLY(a_load_free, clk, rst_n, emit.load, !out_busy)
    // No input is taken during the clearing sweep.
    `ASSERT_IMPLY(a_clear_stall, clk, rst_n, status.clearing, in_stall)
    // A loaded result is presented in the next cycle.
    `ASSERT_NEXT(a_load_shows, clk, rst_n, emit.load, out_valid)

endmodule

`default_nettype wire
